// ===== rtl/core/rma_pkg.sv =====
// Package for the resource map allocator: shared constants, operation and
// status codes, and the packed request and response types. No dependencies.
package rma_pkg;

    localparam int MaxSegmentsDefault = 64;
    localparam int AddrWidthDefault   = 32;
    localparam int LimitWidth         = 7;
    localparam logic [LimitWidth-1:0] LimitReset = 7'd64;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_GET   = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_ERROR   = 2'd2;
    localparam logic [1:0] ST_LOST    = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] req_size;
        logic [31:0] req_addr;
    } req_t;

    typedef struct packed {
        logic [31:0] result_addr;
        logic [1:0]  status;
        logic [31:0] drop_start;
        logic [31:0] drop_end;
    } rsp_t;

endpackage

// ===== rtl/core/rma_table.sv =====
// Segment table memory: start and length stored together, one write port
// and one registered read port. Depends on nothing.
module rma_table #(
    parameter int DEPTH = 64,
    parameter int AW    = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [2*AW-1:0]          wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [2*AW-1:0]          rdata
);
    logic [2*AW-1:0] mem [DEPTH];

    // Synchronous write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/core/rma_engine.sv =====
// Sequencer for allocate, free and get over the segment table, with
// end-address adders shared across its states. Depends on rma_pkg and rma_table.
module rma_engine #(
    parameter int MAX_SEGMENTS = rma_pkg::MaxSegmentsDefault,
    parameter int ADDR_WIDTH   = rma_pkg::AddrWidthDefault
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  rma_pkg::req_t req,
    input  logic [rma_pkg::LimitWidth-1:0] limit,
    output logic          busy,
    output logic          done,
    output rma_pkg::rsp_t rsp
);
    import rma_pkg::*;

    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int AW = ADDR_WIDTH;
    localparam logic [AW-1:0] AMAX = {AW{1'b1}};

    typedef enum logic [4:0] {
        S_IDLE, S_RD, S_WAIT, S_SCAN, S_PREV_RD, S_PREV_WAIT, S_DECIDE,
        S_SHR_RD, S_SHR_WAIT, S_SHR_WR, S_SHL_RD, S_SHL_WAIT, S_SHL_WR,
        S_DROP_RD, S_DROP_WAIT, S_DROP_B, S_FINISH
    } state_t;

    state_t          state_reg;
    logic [1:0]      op_reg;
    logic [AW-1:0]   size_reg, addr_reg;
    logic [CW-1:0]   count_reg, idx_reg, k_reg, ins_idx_reg;
    logic [AW-1:0]   ps_reg, pl_reg;       // previous (i-1) entry
    logic [AW-1:0]   cs_reg, cl_reg;       // current (i) entry
    logic            have_cur_reg;
    logic [2*AW-1:0] ins_data_reg;
    logic            pass_reg;
    logic            rescan_reg;           // free rescans once the shift is done
    logic            again_reg;            // free is in its second scan
    logic [AW-1:0]   res_reg, ls_reg, le_reg;
    logic [1:0]      st_reg;
    logic            done_reg;

    logic            we;
    logic [IW-1:0]   waddr, raddr;
    logic [2*AW-1:0] wdata, rdata;
    logic [AW-1:0]   r_start, r_len;

    rma_table #(.DEPTH(MAX_SEGMENTS), .AW(AW)) u_table (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign r_start = rdata[2*AW-1:AW];
    assign r_len   = rdata[AW-1:0];

    // Saturated slot limit.
    logic [CW:0] eff_limit;
    always_comb
    begin
        if (limit < 7'd2)
        begin
            eff_limit = (CW+1)'(2);
        end
        else if ({{(CW+8){1'b0}}, limit} > (CW+8+7)'(MAX_SEGMENTS))
        begin
            eff_limit = (CW+1)'(MAX_SEGMENTS);
        end
        else
        begin
            eff_limit = (CW+1)'(limit);
        end
    end
    logic full;
    assign full = {1'b0, count_reg} >= eff_limit;

    // Shared adder: end of the entry being read.
    logic [AW:0] r_end;
    assign r_end = {1'b0, r_start} + {1'b0, r_len};
    logic [AW:0] req_end;
    assign req_end = {1'b0, addr_reg} + {1'b0, size_reg};
    logic [AW:0] prev_end;
    assign prev_end = {1'b0, ps_reg} + {1'b0, pl_reg};

    logic bad_range;
    assign bad_range = (addr_reg == '0) || (size_reg == '0) || (size_reg > (AMAX - addr_reg));

    // Read address mux; the address is held through the wait state so the
    // registered read data stays on the same entry.
    always_comb
    begin
        raddr = idx_reg[IW-1:0];
        unique case (state_reg)
            S_PREV_RD, S_PREV_WAIT: raddr = IW'(idx_reg - 1'b1);
            S_SHR_RD, S_SHR_WAIT:   raddr = IW'(k_reg - 1'b1);
            S_SHL_RD, S_SHL_WAIT:   raddr = IW'(k_reg + 1'b1);
            S_DROP_RD, S_DROP_WAIT: raddr = IW'(count_reg - 1'b1);
            S_DROP_B:               raddr = IW'(count_reg - 2'd2);
            default:                raddr = idx_reg[IW-1:0];
        endcase
    end

    assign busy = state_reg != S_IDLE;
    assign done = done_reg;
    assign rsp.result_addr = 32'(res_reg);
    assign rsp.status      = st_reg;
    assign rsp.drop_start  = 32'(ls_reg);
    assign rsp.drop_end    = 32'(le_reg);

    // Write port driven from registered control.
    logic            we_reg;
    logic [IW-1:0]   waddr_reg;
    logic [2*AW-1:0] wdata_reg;
    assign we = we_reg;
    assign waddr = waddr_reg;
    assign wdata = wdata_reg;

    // Main sequencer: scan, then shift entries one at a time through read, wait and write states.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
            we_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            we_reg   <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg   <= req.op;
                        size_reg <= AW'(req.req_size);
                        addr_reg <= AW'(req.req_addr);
                        idx_reg  <= '0;
                        pass_reg <= 1'b0;
                        rescan_reg <= 1'b0;
                        again_reg  <= 1'b0;
                        res_reg  <= '0;
                        ls_reg   <= '0;
                        le_reg   <= '0;
                        st_reg   <= ST_OK;
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    if (op_reg != OP_ALLOC && op_reg != OP_FREE && op_reg != OP_GET)
                    begin
                        st_reg <= ST_ERROR;
                        state_reg <= S_FINISH;
                    end
                    else if (op_reg == OP_ALLOC && size_reg == '0)
                    begin
                        st_reg <= ST_ERROR;
                        state_reg <= S_FINISH;
                    end
                    else if (op_reg != OP_ALLOC && bad_range)
                    begin
                        st_reg <= ST_ERROR;
                        state_reg <= S_FINISH;
                    end
                    else if (idx_reg >= count_reg)
                    begin
                        have_cur_reg <= 1'b0;
                        if (op_reg == OP_FREE)
                        begin
                            state_reg <= (idx_reg != '0) ? S_PREV_RD : S_DECIDE;
                        end
                        else
                        begin
                            st_reg <= ST_NOSPACE;
                            state_reg <= S_FINISH;
                        end
                    end
                    else
                    begin
                        state_reg <= S_WAIT;
                    end
                end
                S_WAIT:
                begin
                    state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    cs_reg <= r_start;
                    cl_reg <= r_len;
                    have_cur_reg <= 1'b1;
                    unique case (op_reg)
                        OP_ALLOC:
                        begin
                            if (r_len >= size_reg)
                            begin
                                res_reg <= r_start;
                                if (r_len == size_reg)
                                begin
                                    k_reg <= idx_reg;
                                    state_reg <= S_SHL_RD;
                                end
                                else
                                begin
                                    we_reg <= 1'b1;
                                    waddr_reg <= idx_reg[IW-1:0];
                                    wdata_reg <= {r_start + size_reg, r_len - size_reg};
                                    state_reg <= S_FINISH;
                                end
                            end
                            else
                            begin
                                idx_reg <= idx_reg + 1'b1;
                                state_reg <= S_RD;
                            end
                        end
                        OP_FREE:
                        begin
                            if (r_start > addr_reg)
                            begin
                                state_reg <= (idx_reg != '0) ? S_PREV_RD : S_DECIDE;
                            end
                            else
                            begin
                                idx_reg <= idx_reg + 1'b1;
                                state_reg <= S_RD;
                            end
                        end
                        default:
                        begin
                            if (r_start <= addr_reg && r_end > {1'b0, addr_reg})
                            begin
                                if (r_end < req_end)
                                begin
                                    st_reg <= ST_NOSPACE;
                                    state_reg <= S_FINISH;
                                end
                                else if (r_start == addr_reg && r_end == req_end)
                                begin
                                    res_reg <= addr_reg;
                                    k_reg <= idx_reg;
                                    state_reg <= S_SHL_RD;
                                end
                                else if (r_start == addr_reg)
                                begin
                                    res_reg <= addr_reg;
                                    we_reg <= 1'b1;
                                    waddr_reg <= idx_reg[IW-1:0];
                                    wdata_reg <= {r_start + size_reg, r_len - size_reg};
                                    state_reg <= S_FINISH;
                                end
                                else if (r_end == req_end)
                                begin
                                    res_reg <= addr_reg;
                                    we_reg <= 1'b1;
                                    waddr_reg <= idx_reg[IW-1:0];
                                    wdata_reg <= {r_start, r_len - size_reg};
                                    state_reg <= S_FINISH;
                                end
                                else if (full)
                                begin
                                    st_reg <= ST_NOSPACE;
                                    state_reg <= S_FINISH;
                                end
                                else
                                begin
                                    res_reg <= addr_reg;
                                    we_reg <= 1'b1;
                                    waddr_reg <= idx_reg[IW-1:0];
                                    wdata_reg <= {r_start, addr_reg - r_start};
                                    ins_idx_reg <= idx_reg + 1'b1;
                                    ins_data_reg <= {AW'(req_end), AW'(r_end - req_end)};
                                    k_reg <= count_reg;
                                    state_reg <= S_SHR_RD;
                                end
                            end
                            else
                            begin
                                idx_reg <= idx_reg + 1'b1;
                                state_reg <= S_RD;
                            end
                        end
                    endcase
                end
                S_PREV_RD:
                begin
                    state_reg <= S_PREV_WAIT;
                end
                S_PREV_WAIT:
                begin
                    state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    logic left, right;
                    left  = 1'b0;
                    right = 1'b0;
                    if (idx_reg != '0)
                    begin
                        left = (r_end == {1'b0, addr_reg});
                    end
                    if (have_cur_reg)
                    begin
                        right = (req_end == {1'b0, cs_reg});
                    end
                    if (idx_reg != '0)
                    begin
                        ps_reg <= r_start;
                        pl_reg <= r_len;
                    end
                    if ((idx_reg != '0 && r_end > {1'b0, addr_reg}) ||
                        (have_cur_reg && req_end > {1'b0, cs_reg}))
                    begin
                        st_reg <= ST_ERROR;
                        ls_reg <= '0;
                        le_reg <= '0;
                        state_reg <= S_FINISH;
                    end
                    else if (left)
                    begin
                        we_reg <= 1'b1;
                        waddr_reg <= IW'(idx_reg - 1'b1);
                        if (right)
                        begin
                            wdata_reg <= {r_start, r_len + size_reg + cl_reg};
                            k_reg <= idx_reg;
                            state_reg <= S_SHL_RD;
                        end
                        else
                        begin
                            wdata_reg <= {r_start, r_len + size_reg};
                            state_reg <= S_FINISH;
                        end
                    end
                    else if (right)
                    begin
                        we_reg <= 1'b1;
                        waddr_reg <= idx_reg[IW-1:0];
                        wdata_reg <= {cs_reg - size_reg, cl_reg + size_reg};
                        state_reg <= S_FINISH;
                    end
                    else if (!full)
                    begin
                        ins_idx_reg <= idx_reg;
                        ins_data_reg <= {addr_reg, size_reg};
                        k_reg <= count_reg;
                        state_reg <= S_SHR_RD;
                    end
                    else
                    begin
                        state_reg <= S_DROP_RD;
                    end
                end
                S_DROP_RD:
                begin
                    state_reg <= S_DROP_WAIT;
                end
                S_DROP_WAIT:
                begin
                    state_reg <= S_DROP_B;
                end
                S_DROP_B:
                begin
                    // Hold last entry; its neighbor arrives next cycle.
                    ps_reg <= r_start;
                    pl_reg <= r_len;
                    state_reg <= S_SHL_WAIT;
                    k_reg <= count_reg - 1'b1;
                    pass_reg <= 1'b1;
                end
                S_SHR_RD:
                begin
                    if (k_reg == ins_idx_reg)
                    begin
                        we_reg <= 1'b1;
                        waddr_reg <= ins_idx_reg[IW-1:0];
                        wdata_reg <= ins_data_reg;
                        count_reg <= count_reg + 1'b1;
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_SHR_WAIT;
                    end
                end
                S_SHR_WAIT:
                begin
                    state_reg <= S_SHR_WR;
                end
                S_SHR_WR:
                begin
                    we_reg <= 1'b1;
                    waddr_reg <= k_reg[IW-1:0];
                    wdata_reg <= rdata;
                    k_reg <= k_reg - 1'b1;
                    state_reg <= S_SHR_RD;
                end
                S_SHL_RD:
                begin
                    if (k_reg + 1'b1 >= count_reg)
                    begin
                        count_reg <= count_reg - 1'b1;
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_SHL_WAIT;
                    end
                end
                S_SHL_WAIT:
                begin
                    if (pass_reg)
                    begin
                        // Drop choice: rdata holds entry count-2, ps/pl entry count-1.
                        pass_reg <= 1'b0;
                        st_reg <= ST_LOST;
                        if (pl_reg > r_len)
                        begin
                            ls_reg <= r_start;
                            le_reg <= AW'(r_end);
                            k_reg <= count_reg - 2'd2;
                            rescan_reg <= !again_reg;
                            state_reg <= S_SHL_RD;
                        end
                        else
                        begin
                            ls_reg <= ps_reg;
                            le_reg <= AW'(prev_end);
                            count_reg <= count_reg - 1'b1;
                            if (again_reg)
                            begin
                                state_reg <= S_FINISH;
                            end
                            else
                            begin
                                again_reg <= 1'b1;
                                idx_reg <= '0;
                                state_reg <= S_RD;
                            end
                        end
                    end
                    else
                    begin
                        state_reg <= S_SHL_WR;
                    end
                end
                S_SHL_WR:
                begin
                    we_reg <= 1'b1;
                    waddr_reg <= k_reg[IW-1:0];
                    wdata_reg <= rdata;
                    k_reg <= k_reg + 1'b1;
                    state_reg <= S_SHL_RD;
                end
                S_FINISH:
                begin
                    // After the first discard the free scans the table once more;
                    // a second discard ends it without placing the range.
                    if (rescan_reg)
                    begin
                        rescan_reg <= 1'b0;
                        again_reg <= 1'b1;
                        idx_reg <= '0;
                        state_reg <= S_RD;
                    end
                    else
                    begin
                        if (st_reg == ST_ERROR || st_reg == ST_NOSPACE)
                        begin
                            ls_reg <= '0;
                            le_reg <= '0;
                        end
                        if (st_reg != ST_OK || op_reg == OP_FREE)
                        begin
                            res_reg <= '0;
                        end
                        done_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// ===== rtl/core/resource_map_allocator.sv =====
// Resource map allocator top level: handshakes, limit register and output
// register around the sequencer. Depends on rma_pkg and rma_engine.
// Each table entry scanned passes through read, wait and scan states, and each
// entry shifted through read, wait and write states; a free that discards a
// segment scans the table again. One request at a time: the next is
// accepted only after the result has been transferred.
// Reset clears the segment count and sets the limit to 64; no clearing pass.
module resource_map_allocator #(
    parameter int MAX_SEGMENTS = rma_pkg::MaxSegmentsDefault,
    parameter int ADDR_WIDTH   = rma_pkg::AddrWidthDefault
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  rma_pkg::req_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output rma_pkg::rsp_t out_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [rma_pkg::LimitWidth-1:0] cfg_data
);
    import rma_pkg::*;

    logic [LimitWidth-1:0] limit_reg;
    logic                  busy, done, out_valid_reg;
    rsp_t                  rsp, out_data_reg;

    rma_engine #(.MAX_SEGMENTS(MAX_SEGMENTS), .ADDR_WIDTH(ADDR_WIDTH)) u_engine (
        .clk(clk), .rst_n(rst_n), .start(in_valid && in_ready), .req(in_data),
        .limit(limit_reg), .busy(busy), .done(done), .rsp(rsp)
    );

    // A result being loaded also blocks the input, so it cannot be overwritten.
    assign in_ready  = !busy && !done && !out_valid_reg;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Limit register and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LimitReset;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                limit_reg <= cfg_data;
            end
            if (done)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= rsp;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end
endmodule

// ===== rtl/core/rma_checker.sv =====
// Port-level checks for the resource map allocator, bound to the top level.
// Depends on rma_pkg.
module rma_port_checks (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input rma_pkg::rsp_t out_data
);
    import rma_pkg::*;

    // No new request is taken while a result waits.
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !in_ready)
        else $error("request accepted with result pending");

    // A request that is offered stays offered until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n) in_valid && !in_ready |=> in_valid)
        else $error("request withdrawn before transfer");

    // A result carries an address only on success.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_OK |-> out_data.result_addr == '0)
        else $error("address on failed result");

    // Lost range is reported only with the discard status.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_LOST |-> out_data.drop_end == '0)
        else $error("lost range without discard");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");
endmodule

bind resource_map_allocator rma_port_checks u_port_checks (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

// ===== verif/rma_checker.sv =====
// Checker for the resource map allocator: watches the request, response and
// limit channels, predicts every response and compares it. Depends on rma_pkg.
module rma_checker
    import rma_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  req_t                  in_data,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  rsp_t                  out_data,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [LimitWidth-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending
);

    localparam int          SLOTS    = MaxSegmentsDefault;
    localparam logic [32:0] ADDR_MAX = 33'h0_FFFF_FFFF;

    // Shadow copy of the free-segment map, kept 33 bits wide so sums never wrap.
    logic [32:0]           seg_base [SLOTS];
    logic [32:0]           seg_len  [SLOTS];
    int                    seg_count;
    logic [LimitWidth-1:0] seg_limit;
    rsp_t                  expected_rsp [$];

    function automatic int usable_slots();
        int l;
        l = seg_limit;
        if (l < 2) l = 2;
        if (l > SLOTS) l = SLOTS;
        return l;
    endfunction

    function automatic void drop_entry(input int i);
        for (int k = i; k + 1 < seg_count; k++) begin
            seg_base[k] = seg_base[k + 1];
            seg_len[k]  = seg_len[k + 1];
        end
        seg_count--;
    endfunction

    function automatic void open_entry(input int i, input logic [32:0] s, input logic [32:0] l);
        for (int k = seg_count; k > i; k--) begin
            seg_base[k] = seg_base[k - 1];
            seg_len[k]  = seg_len[k - 1];
        end
        seg_base[i] = s;
        seg_len[i]  = l;
        seg_count++;
    endfunction

    // First fit: carve the request from the bottom of the lowest large segment.
    function automatic logic [1:0] carve_first_fit(input logic [32:0] size,
                                                   output logic [32:0] res);
        res = '0;
        if (size == 0) return ST_ERROR;
        for (int i = 0; i < seg_count; i++) begin
            if (seg_len[i] >= size) begin
                res = seg_base[i];
                seg_base[i] = seg_base[i] + size;
                seg_len[i]  = seg_len[i] - size;
                if (seg_len[i] == 0) drop_entry(i);
                return ST_OK;
            end
        end
        return ST_NOSPACE;
    endfunction

    // Return a range, merging with neighbors; on a full map one segment is lost.
    function automatic logic [1:0] return_range(input logic [32:0] size,
                                                input logic [32:0] addr,
                                                output logic [32:0] ls,
                                                output logic [32:0] le);
        logic [1:0]  st;
        logic [32:0] fin;
        logic [32:0] pe;
        bit          left;
        bit          right;
        int          i;
        int          b;
        st = ST_OK;
        ls = '0;
        le = '0;
        if (addr == 0 || size == 0 || size > ADDR_MAX - addr) return ST_ERROR;
        fin = addr + size;
        for (int pass = 0; pass < 2; pass++) begin
            i = 0;
            while (i < seg_count && seg_base[i] <= addr) i++;
            left = 1'b0;
            if (i > 0) begin
                pe = seg_base[i - 1] + seg_len[i - 1];
                if (pe > addr) return ST_ERROR;
                left = (pe == addr);
            end
            right = 1'b0;
            if (i < seg_count) begin
                if (fin > seg_base[i]) return ST_ERROR;
                right = (fin == seg_base[i]);
            end
            if (left) begin
                seg_len[i - 1] = seg_len[i - 1] + size;
                if (right) begin
                    seg_len[i - 1] = seg_len[i - 1] + seg_len[i];
                    drop_entry(i);
                end
                return st;
            end
            if (right) begin
                seg_base[i] = seg_base[i] - size;
                seg_len[i]  = seg_len[i] + size;
                return st;
            end
            if (seg_count < usable_slots()) begin
                open_entry(i, addr, size);
                return st;
            end
            // Map is full: discard the smaller of the last two, the last on a tie.
            b = seg_count - 1;
            if (seg_len[b] > seg_len[b - 1]) b--;
            ls = seg_base[b];
            le = seg_base[b] + seg_len[b];
            drop_entry(b);
            st = ST_LOST;
        end
        return st;
    endfunction

    // Claim an exact range, splitting the holding segment when needed.
    function automatic logic [1:0] claim_range(input logic [32:0] size,
                                               input logic [32:0] addr,
                                               output logic [32:0] res);
        logic [32:0] s;
        logic [32:0] e;
        logic [32:0] fin;
        int          i;
        res = '0;
        if (addr == 0 || size == 0 || size > ADDR_MAX - addr) return ST_ERROR;
        fin = addr + size;
        for (i = 0; i < seg_count; i++) begin
            if (seg_base[i] <= addr && seg_base[i] + seg_len[i] > addr) break;
        end
        if (i >= seg_count) return ST_NOSPACE;
        s = seg_base[i];
        e = s + seg_len[i];
        if (e < fin) return ST_NOSPACE;
        if (s == addr) begin
            if (e == fin) begin
                drop_entry(i);
            end else begin
                seg_base[i] = seg_base[i] + size;
                seg_len[i]  = seg_len[i] - size;
            end
        end else if (e == fin) begin
            seg_len[i] = seg_len[i] - size;
        end else begin
            if (seg_count >= usable_slots()) return ST_NOSPACE;
            open_entry(i + 1, fin, e - fin);
            seg_len[i] = addr - s;
        end
        res = addr;
        return ST_OK;
    endfunction

    function automatic rsp_t apply_request(input req_t r);
        logic [32:0] res;
        logic [32:0] ls;
        logic [32:0] le;
        logic [1:0]  st;
        rsp_t        o;
        res = '0;
        ls  = '0;
        le  = '0;
        case (r.op)
            OP_ALLOC: st = carve_first_fit({1'b0, r.req_size}, res);
            OP_FREE:  st = return_range({1'b0, r.req_size}, {1'b0, r.req_addr}, ls, le);
            OP_GET:   st = claim_range({1'b0, r.req_size}, {1'b0, r.req_addr}, res);
            default:  st = ST_ERROR;
        endcase
        if (st != ST_OK) res = '0;
        if (st != ST_LOST)
        begin
            ls = '0;
            le = '0;
        end
        o.result_addr = res[31:0];
        o.status      = st;
        o.drop_start  = ls[31:0];
        o.drop_end    = le[31:0];
        return o;
    endfunction

    // Track transfers on all three channels and compare each response.
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        int   errs;
        errs = 0;
        if (!rst_n)
        begin
            seg_count = 0;
            seg_limit = LimitReset;
            for (int k = 0; k < SLOTS; k++)
            begin
                seg_base[k] = '0;
                seg_len[k]  = '0;
            end
            expected_rsp.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready) seg_limit = cfg_data;
            if (in_valid && in_ready) expected_rsp.push_back(apply_request(in_data));
            if (out_valid && out_ready)
            begin
                if (expected_rsp.size() == 0)
                begin
                    $error("response transfer with nothing expected: %h", out_data);
                    errs++;
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    if (out_data.result_addr !== want.result_addr)
                    begin
                        $error("result_addr: expected %h, got %h", want.result_addr,
                               out_data.result_addr);
                        errs++;
                    end
                    if (out_data.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, out_data.status);
                        errs++;
                    end
                    if (out_data.drop_start !== want.drop_start)
                    begin
                        $error("drop_start: expected %h, got %h", want.drop_start,
                               out_data.drop_start);
                        errs++;
                    end
                    if (out_data.drop_end !== want.drop_end)
                    begin
                        $error("drop_end: expected %h, got %h", want.drop_end,
                               out_data.drop_end);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
            pending <= expected_rsp.size();
        end
    end

endmodule

// ===== verif/resource_map_allocator_tb.sv =====
// Testbench top for resource_map_allocator: clock, reset, request and limit stimulus,
// response back-pressure and verdict. Depends on it, rma_pkg and rma_checker.
module resource_map_allocator_tb;
    import rma_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int PHASE_ITEMS = 250;
    localparam int DRAIN_WAIT  = 600;

    typedef struct {
        logic [31:0] base;
        logic [31:0] len;
    } span_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    req_t                  in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    rsp_t                  out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [LimitWidth-1:0] cfg_data = '0;
    int                    fail_count;
    int                    pending;

    int    sender_idle_pct = 0;
    int    stall_pct = 0;
    logic  hold_req = 1'b0;
    logic  hold_done = 1'b0;
    int    hold_left = 0;
    int    cycle_count = 0;
    int    sent_count = 0;
    int    granted = 0;
    int    discards = 0;
    req_t  sent_log [$];
    span_t held [$];

    resource_map_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    rma_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #6 clk = ~clk;

    // Run guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Response back-pressure, with one long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            hold_left <= 400;
            hold_done <= 1'b1;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Keep the list of ranges granted to us so later frees are well formed.
    always @(posedge clk)
    begin
        req_t r;
        if (out_valid && out_ready && sent_log.size() > 0)
        begin
            r = sent_log.pop_front();
            if (out_data.status == ST_LOST) discards++;
            if (out_data.status == ST_OK && (r.op == OP_ALLOC || r.op == OP_GET))
            begin
                granted++;
                held.push_back('{out_data.result_addr, r.req_size});
            end
        end
    end

    task automatic send_request(input logic [1:0] op, input logic [31:0] size,
                                input logic [31:0] addr);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{op: op, req_size: size, req_addr: addr};
        do @(posedge clk); while (!in_ready);
        sent_log.push_back('{op: op, req_size: size, req_addr: addr});
        sent_count++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_limit(input logic [LimitWidth-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // One random request: mostly well-formed traffic on a small region, some noise.
    task automatic random_request();
        int          pick;
        int          idx;
        span_t       sp;
        logic [31:0] part;
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            send_request(OP_ALLOC, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2000)
                                                                : $urandom_range(1, 40), 0);
        end
        else if (pick < 55 && held.size() > 0)
        begin
            // Give back a granted range, whole or its low part.
            idx = $urandom_range(0, held.size() - 1);
            sp = held[idx];
            held.delete(idx);
            part = ($urandom_range(0, 1) && sp.len > 1) ? $urandom_range(1, sp.len - 1) : sp.len;
            if (part != sp.len) held.push_back('{sp.base + part, sp.len - part});
            send_request(OP_FREE, part, sp.base);
        end
        else if (pick < 72)
        begin
            send_request(OP_FREE, $urandom_range(1, 64), $urandom_range(1, 20000));
        end
        else if (pick < 88)
        begin
            send_request(OP_GET, $urandom_range(1, 24), $urandom_range(1, 20000));
        end
        else
        begin
            send_request(2'($urandom_range(0, 3)),
                         $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 64),
                         $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 20000));
        end
    endtask

    initial
    begin
        logic [LimitWidth-1:0] limits [8];
        int                    senders [8];
        int                    stalls [8];
        limits  = '{7'd64, 7'd2, 7'd5, 7'd127, 7'd0, 7'd1, 7'd12, 7'd64};
        senders = '{0, 76, 0, 23, 0, 23, 0, 76};
        stalls  = '{0, 0, 76, 23, 0, 23, 76, 0};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty map, bad arguments, the full address space, merges and splits.
        send_request(OP_ALLOC, 32'd8, 0);
        send_request(OP_GET, 32'd4, 32'd10);
        send_request(OP_ALLOC, 32'd0, 0);
        send_request(OP_FREE, 32'd0, 32'd50);
        send_request(OP_FREE, 32'd5, 32'd0);
        send_request(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_FREE, 32'd1, 32'hFFFF_FFFF);
        send_request(OP_FREE, 32'hFFFF_FFFE, 32'd1);
        send_request(OP_ALLOC, 32'hFFFF_FFFF, 0);
        send_request(OP_GET, 32'hFFFF_FFFE, 32'd1);
        send_request(OP_FREE, 32'd10, 32'd100);
        send_request(OP_FREE, 32'd10, 32'd120);
        send_request(OP_FREE, 32'd10, 32'd110);
        send_request(OP_FREE, 32'd2, 32'd105);
        send_request(OP_GET, 32'd5, 32'd105);
        send_request(OP_GET, 32'd5, 32'd100);
        send_request(OP_GET, 32'd5, 32'd125);
        send_request(OP_GET, 32'd1, 32'd200);
        send_request(OP_GET, 32'd20, 32'd110);
        send_request(OP_FREE, 32'd4, 32'd96);
        send_request(OP_ALLOC, 32'd15, 0);
        send_request(OP_ALLOC, 32'd4, 0);
        drain();
        held.delete();

        // Random phases, each under its own limit and idling pattern.
        for (int ph = 0; ph < 8; ph++)
        begin
            write_limit(limits[ph]);
            sender_idle_pct = senders[ph];
            stall_pct = stalls[ph];
            if (ph == 0) hold_req <= 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) random_request();
            drain();
        end

        if (pending != 0)
        begin
            $error("%0d responses never arrived", pending);
        end
        $display("Covered %0d requests in 8 phases of slot limits and idling, with one long",
                 sent_count);
        $display("output hold-off; %0d ranges granted, %0d segments discarded on full maps.",
                 granted, discards);
        if (fail_count == 0 && pending == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/rma_pkg.sv
rtl/core/rma_table.sv
rtl/core/rma_engine.sv
rtl/core/resource_map_allocator.sv
rtl/core/rma_checker.sv
verif/rma_checker.sv
verif/resource_map_allocator_tb.sv
